### src/bloom_filter_two_hash_macros.svh
// Assertion macros for the bloom filter RTL.
// No dependencies; include with the bare file name.
`ifndef BLOOM_FILTER_TWO_HASH_MACROS_SVH
`define BLOOM_FILTER_TWO_HASH_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define BFTH_ASSERT_SAME(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define BFTH_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

### src/bfth_pkg.sv
// Package for the two-hash bloom filter: widths, seeds, codes and the
// controller/datapath command and status types. No dependencies.
package bfth_pkg;

  localparam int HASH_W    = 32;
  localparam int DATA_W    = 8;
  localparam int CFG_W     = 19;
  localparam int DIV_STEPS = HASH_W;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);
  localparam int APB_AW    = 3;

  localparam int BFTH_FILTER_BITS = 262144;

  localparam logic [HASH_W-1:0] AP_SEED      = 32'hAAAAAAAA;
  localparam logic [HASH_W-1:0] OAAT_SEED    = 32'h0;
  localparam logic [CFG_W-1:0]  FSIZE_RESET  = 19'd262144;

  // Register index decoded from paddr[APB_AW-1:2]
  localparam logic [APB_AW-3:0] REG_FILTER_SIZE = 1'b0;

  // Action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  typedef struct packed {
    logic load_byte;
    logic upd1;
    logic upd2;
    logic fin1;
    logic fin2;
    logic div_start;
    logic div_sel;
    logic cap_i1;
    logic cap_i2;
    logic mem_we;
    logic idx_sel;
    logic cap_hit1;
    logic seed;
    logic clr_step;
  } bfth_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic clear_done;
    logic div_done;
    logic last;
    logic action;
    logic hit;
  } bfth_status_t;

endpackage

### src/bloom_filter_two_hash.sv
// Top level of the two-hash bloom filter: APB register, stream ports and
// result register. Depends on bfth_pkg, bfth_ctrl and bfth_dp.
//
// Use:
//   Send words one byte per beat on in_*: tdata carries the byte, tuser the
//   action (0 insert, 1 query), tlast marks the final byte of a word.
//   A query's final byte yields one beat on out_*, tdata[0] = 1 when both
//   hashed bits are set; inserts and non-final bytes give no beat.
//   filter_size (APB byte address 0) sets the modulus; write it only idle.
// Sequence:
//   A non-final byte passes through the accept, UPD1 and UPD2 states. A
//   final byte goes on through FIN1 and FIN2 (hash update and avalanche),
//   two 32-step remainder passes, then two store writes for an insert or
//   the lookup states RD1 to RD3 for a query; the beat follows.
// Reset:
//   rst_n is synchronous, active low. After reset the controller sweeps the
//   bit store, one entry per cycle over all FILTER_BITS entries, with in_tready low.
// Backpressure:
//   The result waits in an output register; the next word's bytes are
//   accepted meanwhile and only a further query result stalls behind it.
module bloom_filter_two_hash
  import bfth_pkg::*;
#(
  parameter int FILTER_BITS = BFTH_FILTER_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,    // [7:0] data_byte
  input  logic              in_tuser,    // [0] action
  input  logic              in_tlast,    // last_byte
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,   // [0] maybe_present, [7:1] zero
  // configuration
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic [CFG_W-1:0] filter_size_r;
  logic             out_valid_r;
  logic             out_bit_r;
  logic             out_free;
  logic             out_load;
  logic             in_ready;
  logic             reg_hit;
  bfth_cmd_t        cmd;
  bfth_status_t     status;

  // Register file
  assign cfg_pready = 1'b1;
  assign reg_hit    = (cfg_paddr[APB_AW-1:2] == REG_FILTER_SIZE);
  assign cfg_prdata = reg_hit ? 32'(filter_size_r) : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_size_r <= FSIZE_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_hit) begin
      filter_size_r <= cfg_pwdata[CFG_W-1:0];
    end
  end

  bfth_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_free (out_free),
    .status   (status),
    .in_ready (in_ready),
    .out_load (out_load),
    .cmd      (cmd)
  );

  bfth_dp #(
    .FILTER_BITS (FILTER_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_action   (in_tuser),
    .in_byte     (in_tdata),
    .in_last     (in_tlast),
    .filter_size (filter_size_r),
    .status      (status)
  );

  assign in_tready = in_ready;

  // Result register: load on a query result, drop once the beat is taken
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_bit_r <= status.hit;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_bit_r};

endmodule

### src/bfth_div.sv
// Bit-serial remainder unit: 32-bit dividend modulo a 19-bit divisor,
// one quotient bit per cycle. Depends on bfth_pkg.
module bfth_div
  import bfth_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [HASH_W-1:0] dividend,
  input  logic [CFG_W-1:0]  divisor,
  output logic              done,
  output logic [CFG_W-1:0]  rem
);

  logic [CNT_W-1:0]  cnt_r;
  logic              done_r;
  logic [HASH_W-1:0] num_r;
  logic [CFG_W-1:0]  den_r;
  logic [CFG_W-1:0]  rem_r;
  logic [CFG_W:0]    trial;
  logic [CFG_W:0]    diff;
  logic [CFG_W-1:0]  rem_nxt;

  // Shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial = {rem_r, num_r[HASH_W-1]};
    diff  = trial - {1'b0, den_r};
    if (trial >= {1'b0, den_r}) begin
      rem_nxt = diff[CFG_W-1:0];
    end else begin
      rem_nxt = trial[CFG_W-1:0];
    end
  end

  // Step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CNT_W'(DIV_STEPS);
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CNT_W'(1));
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  // Operands and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      den_r <= divisor;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      num_r <= {num_r[HASH_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

### src/bfth_mem.sv
// Filter bit store: one-bit memory with a registered read port, one write
// port and a clearing sweep after reset. Depends on bfth_pkg.
module bfth_mem
  import bfth_pkg::*;
#(
  parameter int FILTER_BITS = BFTH_FILTER_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           clr_step,
  input  logic                           we,
  input  logic [$clog2(FILTER_BITS)-1:0] wr_addr,
  input  logic [$clog2(FILTER_BITS)-1:0] rd_addr,
  output logic                           rd_bit,
  output logic                           clear_last,
  output logic                           clear_done
);

  localparam int AW = $clog2(FILTER_BITS);

  logic          mem [FILTER_BITS];
  logic          rd_bit_r;
  logic [AW-1:0] clr_addr_r;
  logic          clear_done_r;
  logic          wr_en;
  logic [AW-1:0] waddr;
  logic          wdata;

  assign clear_last = (clr_addr_r == AW'(FILTER_BITS - 1));

  // Sweep address and sticky done flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r   <= '0;
      clear_done_r <= 1'b0;
    end else if (clr_step) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clear_last) begin
        clear_done_r <= 1'b1;
      end
    end
  end

  // Clearing writes zero, inserts write one
  always_comb begin
    wr_en = clr_step | we;
    waddr = clr_step ? clr_addr_r : wr_addr;
    wdata = ~clr_step;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    rd_bit_r <= mem[rd_addr];
  end

  assign rd_bit     = rd_bit_r;
  assign clear_done = clear_done_r;

endmodule

### src/bfth_dp.sv
// Datapath: running AP and one-at-a-time hashes, remainder unit, bit
// indices and the filter store. Depends on bfth_pkg, bfth_div, bfth_mem.
module bfth_dp
  import bfth_pkg::*;
#(
  parameter int FILTER_BITS = BFTH_FILTER_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bfth_cmd_t         cmd,
  input  logic              in_action,
  input  logic [DATA_W-1:0] in_byte,
  input  logic              in_last,
  input  logic [CFG_W-1:0]  filter_size,
  output bfth_status_t      status
);

  localparam int AW = $clog2(FILTER_BITS);

  logic [DATA_W-1:0]   byte_r;
  logic                action_r;
  logic                last_r;
  logic [HASH_W-1:0]   ap_r;
  logic [HASH_W-1:0]   oaat_r;
  logic                odd_r;
  logic [AW-1:0]       i1_r;
  logic [AW-1:0]       i2_r;
  logic                hit1_r;

  logic [HASH_W-1:0]   c_ext;
  logic [HASH_W+4:0]   ap_prod;
  logic [HASH_W-1:0]   ap_upd;
  logic [HASH_W-1:0]   oaat_y;
  logic [HASH_W-1:0]   fin_y;
  logic [CFG_W-1:0]    eff_size;
  logic                div_done;
  logic [CFG_W-1:0]    div_rem;
  logic [AW-1:0]       idx;
  logic                rd_bit;
  logic                clear_last;
  logic                clear_done;

  assign c_ext = {{(HASH_W - DATA_W){1'b0}}, byte_r};

  // AP step: even positions use a multiply, odd positions an add
  always_comb begin
    ap_prod = {8'b0, ap_r[HASH_W-1:3]} * {{(HASH_W - 3){1'b0}}, byte_r};
    if (!odd_r) begin
      ap_upd = ap_r ^ ({ap_r[HASH_W-8:0], 7'b0} ^ ap_prod[HASH_W-1:0]);
    end else begin
      ap_upd = ap_r ^ (~{ap_r[HASH_W-12:0], 11'b0} + (c_ext ^ {5'b0, ap_r[HASH_W-1:5]}));
    end
  end

  // One-at-a-time mix and first half of the final avalanche
  assign oaat_y = oaat_r + {oaat_r[HASH_W-11:0], 10'b0};
  assign fin_y  = oaat_r + {oaat_r[HASH_W-4:0], 3'b0};

  // Clamp the modulus into one to FILTER_BITS
  always_comb begin
    eff_size = filter_size;
    if (filter_size == '0) begin
      eff_size = CFG_W'(1);
    end else if (32'(filter_size) > 32'(FILTER_BITS)) begin
      eff_size = CFG_W'(FILTER_BITS);
    end
  end

  // Latch the accepted byte
  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      byte_r   <= in_byte;
      action_r <= in_action;
      last_r   <= in_last;
    end
  end

  // Running hash state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ap_r   <= AP_SEED;
      oaat_r <= OAAT_SEED;
      odd_r  <= 1'b0;
    end else if (cmd.seed) begin
      ap_r   <= AP_SEED;
      oaat_r <= OAAT_SEED;
      odd_r  <= 1'b0;
    end else begin
      if (cmd.upd1) begin
        ap_r   <= ap_upd;
        oaat_r <= oaat_r + c_ext;
      end
      if (cmd.upd2) begin
        oaat_r <= oaat_y ^ {6'b0, oaat_y[HASH_W-1:6]};
        odd_r  <= ~odd_r;
      end
      if (cmd.fin1) begin
        oaat_r <= fin_y ^ {11'b0, fin_y[HASH_W-1:11]};
      end
      if (cmd.fin2) begin
        oaat_r <= oaat_r + {oaat_r[HASH_W-16:0], 15'b0};
      end
    end
  end

  bfth_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (cmd.div_sel ? oaat_r : ap_r),
    .divisor  (eff_size),
    .done     (div_done),
    .rem      (div_rem)
  );

  // Capture indices and the first looked-up bit
  always_ff @(posedge clk) begin
    if (cmd.cap_i1) begin
      i1_r <= AW'(div_rem);
    end
    if (cmd.cap_i2) begin
      i2_r <= AW'(div_rem);
    end
    if (cmd.cap_hit1) begin
      hit1_r <= rd_bit;
    end
  end

  assign idx = cmd.idx_sel ? i2_r : i1_r;

  bfth_mem #(
    .FILTER_BITS (FILTER_BITS)
  ) u_mem (
    .clk        (clk),
    .rst_n      (rst_n),
    .clr_step   (cmd.clr_step),
    .we         (cmd.mem_we),
    .wr_addr    (idx),
    .rd_addr    (idx),
    .rd_bit     (rd_bit),
    .clear_last (clear_last),
    .clear_done (clear_done)
  );

  always_comb begin
    status.clear_last = clear_last;
    status.clear_done = clear_done;
    status.div_done   = div_done;
    status.last       = last_r;
    status.action     = action_r;
    status.hit        = hit1_r & rd_bit;
  end

endmodule

### src/bfth_ctrl.sv
// Controller state machine: clearing sweep, byte hashing, word-end
// reduction, bit set or lookup. Depends on bfth_pkg and the macros header.
`include "bloom_filter_two_hash_macros.svh"

module bfth_ctrl
  import bfth_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         out_free,
  input  bfth_status_t status,
  output logic         in_ready,
  output logic         out_load,
  output bfth_cmd_t    cmd
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_UPD1  = 4'd2;
  localparam logic [3:0] S_UPD2  = 4'd3;
  localparam logic [3:0] S_FIN1  = 4'd4;
  localparam logic [3:0] S_FIN2  = 4'd5;
  localparam logic [3:0] S_DIVA  = 4'd6;
  localparam logic [3:0] S_DIVB  = 4'd7;
  localparam logic [3:0] S_WR1   = 4'd8;
  localparam logic [3:0] S_WR2   = 4'd9;
  localparam logic [3:0] S_RD1   = 4'd10;
  localparam logic [3:0] S_RD2   = 4'd11;
  localparam logic [3:0] S_RD3   = 4'd12;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_byte = 1'b1;
          state_nxt     = S_UPD1;
        end
      end
      S_UPD1: begin
        cmd.upd1  = 1'b1;
        state_nxt = S_UPD2;
      end
      S_UPD2: begin
        cmd.upd2  = 1'b1;
        state_nxt = status.last ? S_FIN1 : S_IDLE;
      end
      S_FIN1: begin
        cmd.fin1  = 1'b1;
        state_nxt = S_FIN2;
      end
      S_FIN2: begin
        cmd.fin2      = 1'b1;
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b0;
        state_nxt     = S_DIVA;
      end
      S_DIVA: begin
        if (status.div_done) begin
          cmd.cap_i1    = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = 1'b1;
          state_nxt     = S_DIVB;
        end
      end
      S_DIVB: begin
        if (status.div_done) begin
          cmd.cap_i2 = 1'b1;
          state_nxt  = (status.action == ACT_QUERY) ? S_RD1 : S_WR1;
        end
      end
      S_WR1: begin
        cmd.mem_we  = 1'b1;
        cmd.idx_sel = 1'b0;
        state_nxt   = S_WR2;
      end
      S_WR2: begin
        cmd.mem_we  = 1'b1;
        cmd.idx_sel = 1'b1;
        cmd.seed    = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_RD1: begin
        cmd.idx_sel = 1'b0;
        state_nxt   = S_RD2;
      end
      S_RD2: begin
        cmd.idx_sel  = 1'b1;
        cmd.cap_hit1 = 1'b1;
        state_nxt    = S_RD3;
      end
      S_RD3: begin
        // hold the second lookup until the result register frees up
        cmd.idx_sel = 1'b1;
        if (out_free) begin
          out_load  = 1'b1;
          cmd.seed  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  `BFTH_ASSERT_SAME(a_div_done_waiting, clk, rst_n, status.div_done, state_r == S_DIVA || state_r == S_DIVB)
  `BFTH_ASSERT_NEXT(a_div_no_early_done, clk, rst_n, cmd.div_start, !status.div_done)
  `BFTH_ASSERT_SAME(a_set_after_clear, clk, rst_n, cmd.mem_we, status.clear_done)

endmodule
